// ===== hdl/differential_drive_ramp_assert.svh =====
// assertion macros used by the differential_drive_ramp rtl file
`ifndef DIFFERENTIAL_DRIVE_RAMP_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_RAMP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DDR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked out of reset
`define DDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/ddr_pkg.sv =====
`default_nettype none

package ddr_pkg;

  localparam int unsigned WireMax    = 254;
  localparam int unsigned WireMid    = WireMax / 2;
  localparam int unsigned SpeedW     = 14;
  localparam int unsigned StepW      = 14;
  localparam int unsigned ScaleShift = 6;

  localparam logic [StepW-1:0] StepReset = StepW'(610);

  typedef logic signed [SpeedW-1:0] speed_t;
  typedef logic [StepW-1:0]         step_t;

  // opcodes carried in tuser
  localparam logic OpCommand = 1'b0;
  localparam logic OpTick    = 1'b1;

  // wire byte to speed, bytes above the top code saturate
  function automatic speed_t decode_wire(input logic [7:0] raw);
    logic [7:0]        w;
    logic signed [8:0] diff;
    w    = (raw > 8'(WireMax)) ? 8'(WireMax) : raw;
    diff = $signed({1'b0, w}) - $signed(9'(WireMid));
    return speed_t'({diff[SpeedW-ScaleShift-1:0], {ScaleShift{1'b0}}});
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ddr_slew.sv =====
`default_nettype none

module ddr_slew (
  input  ddr_pkg::speed_t speed_i,
  input  ddr_pkg::speed_t target_i,
  input  ddr_pkg::step_t  step_i,
  output ddr_pkg::speed_t speed_o
);
  import ddr_pkg::*;

  // two extra bits cover a full-scale speed plus the largest step
  localparam int unsigned WideW = SpeedW + 2;

  logic signed [WideW-1:0] v, t, s, dn, up;

  assign v  = WideW'(speed_i);
  assign t  = WideW'(target_i);
  assign s  = $signed({2'b00, step_i});
  assign dn = v - s;
  assign up = v + s;

  always_comb begin
    if (v > t) begin
      speed_o = (dn < t) ? target_i : speed_t'(dn);
    end else if (v < t) begin
      speed_o = (up > t) ? target_i : speed_t'(up);
    end else begin
      speed_o = speed_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/differential_drive_ramp.sv =====
`default_nettype none

// Two-channel speed ramp for a differential drive. Each input word is a command
// (tuser 0: left and right wire bytes, 127 means stop, 255 reads as 254) or a tick
// (tuser 1: every speed moves by the programmed step toward its target and stops on it).
// Commands are ignored until a stop-stop pair arrives; that pair arms the block.
// On a tick with both targets zero and speeds not of opposite sign, the faster
// side is pulled to the slower one so the robot halts straight. Every input word
// gives exactly one output word with the speeds after the update, the on-target
// flag and the armed flag. Each word passes the input register, then the output register;
// one word is taken every cycle while m_axis_tready is high: the whole update is one add,
// compare and clamp per channel between the input register and the speed state. The step
// register must be written via cfg_we_i only while no word is in flight (not enforced).
module differential_drive_ramp (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire ddr_pkg::step_t  cfg_wdata_i,
  input  wire                  s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire [15:0]           s_axis_tdata,  // left_byte [7:0], right_byte [15:8]
  input  wire                  s_axis_tuser,  // opcode
  output logic                 m_axis_tvalid,
  input  wire                  m_axis_tready,
  // left_drive [13:0], right_drive [27:14], on_target [28], armed [29], zero [31:30]
  output logic [31:0]          m_axis_tdata
);
  import ddr_pkg::*;

  `include "differential_drive_ramp_assert.svh"

  step_t      step_q;
  logic       in_valid_q;
  logic       op_q;
  logic [7:0] lbyte_q, rbyte_q;
  logic       out_valid_q;
  logic [31:0] out_data_q;

  speed_t left_speed_q, right_speed_q, left_target_q, right_target_q;
  speed_t left_speed_d, right_speed_d, left_target_d, right_target_d;
  logic   armed_q, armed_d;

  speed_t left_slew, right_slew, left_cmd, right_cmd;
  logic   advance;
  logic   on_target;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepReset;
    end else if (cfg_we_i) begin
      step_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      op_q    <= s_axis_tuser;
      lbyte_q <= s_axis_tdata[7:0];
      rbyte_q <= s_axis_tdata[15:8];
    end
  end

  ddr_slew u_slew_left (
    .speed_i  (left_speed_q),
    .target_i (left_target_q),
    .step_i   (step_q),
    .speed_o  (left_slew)
  );

  ddr_slew u_slew_right (
    .speed_i  (right_speed_q),
    .target_i (right_target_q),
    .step_i   (step_q),
    .speed_o  (right_slew)
  );

  assign left_cmd  = decode_wire(lbyte_q);
  assign right_cmd = decode_wire(rbyte_q);

  logic [SpeedW:0] left_mag, right_mag;
  logic            opposite;

  assign left_mag  = left_slew[SpeedW-1]  ? -(SpeedW+1)'(left_slew)  : (SpeedW+1)'(left_slew);
  assign right_mag = right_slew[SpeedW-1] ? -(SpeedW+1)'(right_slew) : (SpeedW+1)'(right_slew);
  assign opposite  = (left_slew < 0 && right_slew > 0) || (left_slew > 0 && right_slew < 0);

  always_comb begin
    left_speed_d   = left_speed_q;
    right_speed_d  = right_speed_q;
    left_target_d  = left_target_q;
    right_target_d = right_target_q;
    armed_d        = armed_q;
    case (op_q)
      OpTick: begin
        left_speed_d  = left_slew;
        right_speed_d = right_slew;
        // straight stop: match the faster side to the slower one
        if (left_target_q == '0 && right_target_q == '0 && !opposite) begin
          if (left_mag < right_mag) begin
            right_speed_d = left_slew;
          end else begin
            left_speed_d = right_slew;
          end
        end
      end
      OpCommand: begin
        armed_d = armed_q || (left_cmd == '0 && right_cmd == '0);
        if (armed_d) begin
          left_target_d  = left_cmd;
          right_target_d = right_cmd;
        end
      end
      default: begin
        armed_d = armed_q;
      end
    endcase
  end

  assign on_target = (left_speed_d == left_target_d) && (right_speed_d == right_target_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_speed_q   <= '0;
      right_speed_q  <= '0;
      left_target_q  <= '0;
      right_target_q <= '0;
      armed_q        <= 1'b0;
    end else if (advance) begin
      left_speed_q   <= left_speed_d;
      right_speed_q  <= right_speed_d;
      left_target_q  <= left_target_d;
      right_target_q <= right_target_d;
      armed_q        <= armed_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {2'b00, armed_d, on_target, right_speed_d, left_speed_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `DDR_ASSERT_NOW(a_unarmed_targets_zero, clk_i, rst_ni, !armed_q,
                  left_target_q == '0 && right_target_q == '0)
  `DDR_ASSERT_NEXT(a_armed_sticks, clk_i, rst_ni, armed_q, armed_q)
  `DDR_ASSERT_NEXT(a_advance_fills_output, clk_i, rst_ni, advance, out_valid_q)
  `DDR_ASSERT_NOW(a_ready_when_output_free, clk_i, rst_ni, !out_valid_q, s_axis_tready)
  `DDR_ASSERT_NOW(a_speed_in_range, clk_i, rst_ni, 1'b1,
                  left_speed_q >= -speed_t'(8128) && left_speed_q <= speed_t'(8128) &&
                  right_speed_q >= -speed_t'(8128) && right_speed_q <= speed_t'(8128))

endmodule

`default_nettype wire
